FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   // operation codes
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   localparam int DEFAULT_SIZE = 16;
   localparam int DATA_W       = 32;
   localparam int OPCODE_W     = 2;
   localparam int OCC_W        = 5;

   // per-cycle command broadcast along the cell row
   typedef struct packed {
      logic                     enq;
      logic                     deq;
      logic signed [DATA_W-1:0] value;
   } spq_ctrl_type;

endpackage

FILE: rtl/spq_cell.sv
// One compare-and-shift cell of the sorted row.
module spq_cell
   import spq_pkg::*;
#(
   parameter int COUNT_W = 5,
   parameter int INDEX   = 0
) (
   input  logic                     clock,
   input  spq_ctrl_type             ctrl,
   input  logic [COUNT_W-1:0]       count,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic                     left_greater,
   input  logic signed [DATA_W-1:0] right_entry,
   output logic signed [DATA_W-1:0] entry,
   output logic                     greater
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     occupied;
   logic                     at_free;

   // occupancy of this slot follows from the count
   assign occupied = COUNT_W'(INDEX) < count;
   assign at_free  = count == COUNT_W'(INDEX);
   assign greater  = occupied && (entry_ff > ctrl.value);
   assign entry    = entry_ff;

   // enqueue: shift up behind the insertion point; dequeue: shift down
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.enq) begin
         if (left_greater) begin
            entry_in = left_entry;
         end else if (greater || at_free) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of compare-and-shift cells with status tracking.
// The result strobes in the cycle after the item is taken on start.
// Throughput: one item per cycle; busy is always low, since every cell updates
//   in the same cycle from its own compare and its neighbours' entries.
// Reset: synchronous; empties the queue (count, smallest, largest to zero).
// Entries are not cleared; the receiver cannot stall results.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int SIZE = DEFAULT_SIZE
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_strobe,
   output logic                       rsp_accepted,
   output logic                       rsp_refused_full,
   output logic signed [DATA_W-1:0]   rsp_smallest,
   output logic signed [DATA_W-1:0]   rsp_largest,
   output logic [OCC_W-1:0]           rsp_occupancy,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   localparam int COUNT_W = $clog2(SIZE + 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SIZE);
   localparam logic [COUNT_W-1:0] ONE_COUNT  = COUNT_W'(1);

   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [DATA_W-1:0] smallest_ff, smallest_in;
   logic signed [DATA_W-1:0] largest_ff, largest_in;
   logic                     strobe_ff;
   logic                     accepted_ff, accepted_in;
   logic                     refused_ff, refused_in;

   logic                     is_enq, is_deq, is_clr;
   logic                     enq_ok, deq_ok;
   logic                     empty, full;
   spq_ctrl_type             ctrl;

   logic signed [DATA_W-1:0] cell_entry [SIZE];
   logic                     cell_greater [SIZE];

   assign busy  = 1'b0;
   assign empty = count_ff == '0;
   assign full  = count_ff == FULL_COUNT;

   // decode the item
   assign is_enq = start && (req_opcode == OP_ENQUEUE);
   assign is_deq = start && (req_opcode == OP_DEQUEUE);
   assign is_clr = start && (req_opcode == OP_CLEAR);
   assign enq_ok = is_enq && !full;
   assign deq_ok = is_deq && !empty;

   assign ctrl.enq   = enq_ok;
   assign ctrl.deq   = deq_ok;
   assign ctrl.value = req_value;

   // cell row
   for (genvar i = 0; i < SIZE; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_e;
      logic                     left_g;
      logic signed [DATA_W-1:0] right_e;
      if (i == 0) begin : g_first
         assign left_e = req_value;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_g = cell_greater[i-1];
      end
      if (i == SIZE - 1) begin : g_last
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      spq_cell #(
         .COUNT_W (COUNT_W),
         .INDEX   (i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .count        (count_ff),
         .left_entry   (left_e),
         .left_greater (left_g),
         .right_entry  (right_e),
         .entry        (cell_entry[i]),
         .greater      (cell_greater[i])
      );
   end

   // count and end-value tracking; both ends read zero when empty
   always_comb begin
      count_in    = count_ff;
      smallest_in = smallest_ff;
      largest_in  = largest_ff;
      priority if (enq_ok) begin
         count_in = count_ff + ONE_COUNT;
         if (empty || (req_value < smallest_ff)) begin
            smallest_in = req_value;
         end
         if (empty || (req_value > largest_ff)) begin
            largest_in = req_value;
         end
      end else if (deq_ok) begin
         count_in = count_ff - ONE_COUNT;
         if (count_ff == ONE_COUNT) begin
            smallest_in = '0;
            largest_in  = '0;
         end else begin
            smallest_in = cell_entry[1];
         end
      end else if (is_clr) begin
         count_in    = '0;
         smallest_in = '0;
         largest_in  = '0;
      end
   end

   assign accepted_in = enq_ok || deq_ok || is_clr;
   assign refused_in  = is_enq && full;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         smallest_ff <= '0;
         largest_ff  <= '0;
         strobe_ff   <= 1'b0;
         accepted_ff <= 1'b0;
         refused_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         smallest_ff <= smallest_in;
         largest_ff  <= largest_in;
         strobe_ff   <= start;
         accepted_ff <= accepted_in;
         refused_ff  <= refused_in;
      end
   end

   // result ports reflect the queue after the last item
   assign rsp_strobe       = strobe_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_refused_full = refused_ff;
   assign rsp_smallest     = smallest_ff;
   assign rsp_largest      = largest_ff;
   assign rsp_occupancy    = OCC_W'(count_ff);
   assign rsp_is_empty     = empty;
   assign rsp_is_full      = full;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("count beyond queue size");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      empty |-> (smallest_ff == '0) && (largest_ff == '0))
      else $error("end values not zero while empty");

   a_order: assert property (@(posedge clock) disable iff (reset)
      !empty |-> smallest_ff <= largest_ff)
      else $error("smallest above largest");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_strobe)
      else $error("no result for accepted item");

   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_refused_full |-> full && !rsp_accepted && rsp_strobe)
      else $error("refusal without full queue");
`endif

endmodule
